// ----- hdl/udp_datagram_header_parser_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the datagram header parser.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef UDP_DATAGRAM_HEADER_PARSER_ASSERT_SVH
`define UDP_DATAGRAM_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside of reset.
`define UDPH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checked on every clock edge, during reset too.
`define UDPH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define UDPH_ASSERT(label, prop, msg)
`define UDPH_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- hdl/udph_pkg.sv -----
// ---------------------------------------------------------------------------
// udph_pkg
// Shared types and constants of the datagram header parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package udph_pkg;

   // Default bound on the counted bytes of one datagram.
   localparam int unsigned MAX_PACKET_BYTES_DEFAULT = 65535;
   // Default depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Reset value of the address length limit.
   localparam logic [15:0] MAX_ADDR_LEN_RESET = 16'd2048;

   // Header layout: byte counts at which the multi-byte fields end, and positions of single bytes.
   localparam logic [15:0] SESSION_END   = 16'd4;
   localparam logic [15:0] PACKET_END    = 16'd6;
   localparam logic [15:0] FRAG_IDX_POS  = 16'd6;
   localparam logic [15:0] FRAG_TOT_POS  = 16'd7;
   localparam logic [15:0] VARINT_POS    = 16'd8;
   localparam logic [15:0] MIN_DGRAM_LEN = 16'd9;
   localparam logic [4:0]  FIXED_HDR_LEN = 5'd8;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_SHORT  = 2'd1,
      ST_TRUNC  = 2'd2,
      ST_FORMAT = 2'd3
   } status_type;

   // One finished datagram as handed from the front to the back.
   typedef struct packed {
      logic [15:0] len;        // saturated byte count
      logic [3:0]  vsize;      // varint size in bytes, zero if not reached
      logic [15:0] vlow;       // low 16 bits of the varint value
      logic        vhigh;      // varint value has bits above bit 15
      logic [31:0] session;    // zero if not reached
      logic [15:0] packet;     // zero if not reached
      logic [7:0]  frag_index; // zero if not reached
      logic [7:0]  frag_total; // zero if not reached
   } rec_type;

endpackage

`default_nettype wire

// ----- hdl/udph_front.sv -----
// ---------------------------------------------------------------------------
// udph_front
// Takes datagram words one byte at a time, collects the header fields and
// the varint, and pushes one record into the queue at the last byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "udp_datagram_header_parser_assert.svh"

module udph_front #(
   parameter int unsigned MAX_PACKET_BYTES = udph_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             req_last_byte,
   input  wire logic             q_full,
   output logic                  q_push,
   output udph_pkg::rec_type     q_rec
);

   logic        accept;
   logic [15:0] pos_ff,     pos_in;
   logic [31:0] session_ff, session_in;
   logic [15:0] packet_ff,  packet_in;
   logic [7:0]  fidx_ff,    fidx_in;
   logic [7:0]  ftot_ff,    ftot_in;
   logic [3:0]  vsize_ff,   vsize_in;
   logic [15:0] vlow_ff,    vlow_in;
   logic        vhigh_ff,   vhigh_in;
   logic        in_varint;

   // The queue full flag holds off every word; it never depends on valid.
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Still inside the varint body when the position is below 8 plus its size.
   assign in_varint = {1'b0, pos_ff} < (17'(udph_pkg::VARINT_POS) + {13'b0, vsize_ff});

   // Fold the current byte into the field that its position selects.
   always_comb begin
      pos_in     = pos_ff;
      session_in = session_ff;
      packet_in  = packet_ff;
      fidx_in    = fidx_ff;
      ftot_in    = ftot_ff;
      vsize_in   = vsize_ff;
      vlow_in    = vlow_ff;
      vhigh_in   = vhigh_ff;
      if (accept && (pos_ff < 16'(MAX_PACKET_BYTES))) begin
         pos_in = pos_ff + 16'd1;
         if (pos_ff < udph_pkg::SESSION_END) begin
            session_in = {session_ff[23:0], req_in_byte};
         end else if (pos_ff < udph_pkg::PACKET_END) begin
            packet_in = {packet_ff[7:0], req_in_byte};
         end else if (pos_ff == udph_pkg::FRAG_IDX_POS) begin
            fidx_in = req_in_byte;
         end else if (pos_ff == udph_pkg::FRAG_TOT_POS) begin
            ftot_in = req_in_byte;
         end else if (pos_ff == udph_pkg::VARINT_POS) begin
            // The top two bits select a size of 1, 2, 4 or 8 bytes.
            vsize_in = 4'd1 << req_in_byte[7:6];
            vlow_in  = {10'b0, req_in_byte[5:0]};
            vhigh_in = 1'b0;
         end else if (in_varint) begin
            // Only whether the value spills past 16 bits matters later.
            vhigh_in = vhigh_ff || (vlow_ff[15:8] != 8'd0);
            vlow_in  = {vlow_ff[7:0], req_in_byte};
         end
      end
   end

   // Record of the finished datagram; fields not reached read as zero.
   always_comb begin
      q_push           = accept && req_last_byte;
      q_rec.len        = pos_in;
      q_rec.vsize      = vsize_in;
      q_rec.vlow       = vlow_in;
      q_rec.vhigh      = vhigh_in;
      q_rec.session    = (pos_in >= udph_pkg::SESSION_END) ? session_in : 32'd0;
      q_rec.packet     = (pos_in >= udph_pkg::PACKET_END) ? packet_in : 16'd0;
      q_rec.frag_index = (pos_in > udph_pkg::FRAG_IDX_POS) ? fidx_in : 8'd0;
      q_rec.frag_total = (pos_in > udph_pkg::FRAG_TOT_POS) ? ftot_in : 8'd0;
   end

   // Per-datagram state clears after the last byte.
   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         pos_ff     <= '0;
         session_ff <= '0;
         packet_ff  <= '0;
         fidx_ff    <= '0;
         ftot_ff    <= '0;
         vsize_ff   <= '0;
         vlow_ff    <= '0;
         vhigh_ff   <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         session_ff <= session_in;
         packet_ff  <= packet_in;
         fidx_ff    <= fidx_in;
         ftot_ff    <= ftot_in;
         vsize_ff   <= vsize_in;
         vlow_ff    <= vlow_in;
         vhigh_ff   <= vhigh_in;
      end
   end

   `UDPH_ASSERT(a_pos_bounded, pos_ff <= 16'(MAX_PACKET_BYTES), "byte position passed its bound")
   `UDPH_ASSERT(a_pos_clears, q_push |=> (pos_ff == 16'd0), "position not cleared after last word")

endmodule

`default_nettype wire

// ----- hdl/udph_queue.sv -----
// ---------------------------------------------------------------------------
// udph_queue
// Short first-in first-out queue of datagram records between the front and
// the back, so that each side can stall on its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "udp_datagram_header_parser_assert.svh"

module udph_queue #(
   parameter int unsigned QUEUE_DEPTH = udph_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire udph_pkg::rec_type push_rec,
   output logic                   full,
   output logic                   not_empty,
   input  wire logic              pop,
   output udph_pkg::rec_type      head_rec
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   udph_pkg::rec_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_rec  = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

   `UDPH_ASSERT(a_count_bounded, count_ff <= DEPTH_CNT, "queue fill count above depth")

endmodule

`default_nettype wire

// ----- hdl/udph_back.sv -----
// ---------------------------------------------------------------------------
// udph_back
// Classifies each queued datagram record, updates the running counters and
// holds the result word in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "udp_datagram_header_parser_assert.svh"

module udph_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [15:0]       csr_wr_data,
   input  wire logic              q_not_empty,
   input  wire udph_pkg::rec_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_session_tag,
   output logic [15:0]            rsp_packet_seq,
   output logic [7:0]             rsp_frag_index,
   output logic [7:0]             rsp_frag_total,
   output logic [4:0]             rsp_addr_offset,
   output logic [15:0]            rsp_addr_length,
   output logic [15:0]            rsp_data_length,
   output logic [31:0]            rsp_good_count,
   output logic [31:0]            rsp_short_err_count,
   output logic [31:0]            rsp_bounds_err_count,
   output logic [31:0]            rsp_format_err_count
);

   logic [15:0]          max_addr_len_ff;
   logic                 rsp_valid_ff;
   udph_pkg::status_type status_ff, status_in;
   logic [31:0]          session_ff;
   logic [15:0]          packet_ff;
   logic [7:0]           fidx_ff;
   logic [7:0]           ftot_ff;
   logic [4:0]           off_ff, off_in;
   logic [15:0]          alen_ff, alen_in;
   logic [15:0]          dlen_ff, dlen_in;
   logic [31:0]          good_ff, short_ff, bounds_ff, format_ff;
   logic [4:0]           hdr_end;
   logic [16:0]          addr_end;
   logic                 value_bad;

   // Address length limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_addr_len_ff <= udph_pkg::MAX_ADDR_LEN_RESET;
      end else if (csr_wr_en) begin
         max_addr_len_ff <= csr_wr_data;
      end
   end

   // Take the head record whenever the output register is free or draining.
   assign q_pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);

   // Status decision for the head record, checked in order of priority.
   always_comb begin
      hdr_end   = udph_pkg::FIXED_HDR_LEN + {1'b0, q_head.vsize};
      addr_end  = {12'b0, hdr_end} + {1'b0, q_head.vlow};
      value_bad = q_head.vhigh || (q_head.vlow == 16'd0) || (q_head.vlow > max_addr_len_ff);
      off_in    = '0;
      alen_in   = '0;
      dlen_in   = '0;
      if (q_head.len < udph_pkg::MIN_DGRAM_LEN) begin
         status_in = udph_pkg::ST_SHORT;
      end else if (q_head.len < {11'b0, hdr_end}) begin
         status_in = udph_pkg::ST_TRUNC;
      end else if (value_bad) begin
         status_in = udph_pkg::ST_FORMAT;
      end else if ({1'b0, q_head.len} <= addr_end) begin
         status_in = udph_pkg::ST_FORMAT;
      end else begin
         status_in = udph_pkg::ST_OK;
         off_in    = hdr_end;
         alen_in   = q_head.vlow;
         dlen_in   = q_head.len - addr_end[15:0];
      end
   end

   // Control state: result valid and the four running counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         good_ff      <= '0;
         short_ff     <= '0;
         bounds_ff    <= '0;
         format_ff    <= '0;
      end else begin
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
            case (status_in)
               udph_pkg::ST_OK:    good_ff   <= good_ff + 32'd1;
               udph_pkg::ST_SHORT: short_ff  <= short_ff + 32'd1;
               udph_pkg::ST_TRUNC: bounds_ff <= bounds_ff + 32'd1;
               default:            format_ff <= format_ff + 32'd1;
            endcase
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff  <= status_in;
         session_ff <= q_head.session;
         packet_ff  <= q_head.packet;
         fidx_ff    <= q_head.frag_index;
         ftot_ff    <= q_head.frag_total;
         off_ff     <= off_in;
         alen_ff    <= alen_in;
         dlen_ff    <= dlen_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_session_tag      = session_ff;
   assign rsp_packet_seq       = packet_ff;
   assign rsp_frag_index       = fidx_ff;
   assign rsp_frag_total       = ftot_ff;
   assign rsp_addr_offset      = off_ff;
   assign rsp_addr_length      = alen_ff;
   assign rsp_data_length      = dlen_ff;
   assign rsp_good_count       = good_ff;
   assign rsp_short_err_count  = short_ff;
   assign rsp_bounds_err_count = bounds_ff;
   assign rsp_format_err_count = format_ff;

   `UDPH_ASSERT(a_one_counter,
      q_pop |=> ($countones({good_ff != $past(good_ff), short_ff != $past(short_ff),
         bounds_ff != $past(bounds_ff), format_ff != $past(format_ff)}) == 1),
      "result did not advance exactly one counter")
   `UDPH_ASSERT(a_ok_offset, (rsp_valid_ff && (status_ff == udph_pkg::ST_OK)) |-> (off_ff >= 5'd9), "good datagram without address offset")

endmodule

`default_nettype wire

// ----- hdl/udp_datagram_header_parser.sv -----
// ---------------------------------------------------------------------------
// udp_datagram_header_parser
// Byte-wide datagram header parser with status and running counters.
// ---------------------------------------------------------------------------
// The parser takes one datagram byte per clock cycle while req_stall is low,
// with req_last_byte marking the final byte, and gives one result word per
// datagram: status, session and packet ids, fragment index and total, the
// address offset and length decoded from the varint, the data length and
// four wrapping counters. Each record passes through the queue into the
// result register, where rsp_valid rises, as long as that is free. A
// four-record queue sits between the byte front end and the classifying
// back end, so req_stall rises only when that queue is full, which happens
// only while rsp_stall holds results back. Write csr_wr_data (the largest
// accepted address length, 2048 after reset) only while no datagram is in
// flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udp_datagram_header_parser #(
   parameter int unsigned MAX_PACKET_BYTES = udph_pkg::MAX_PACKET_BYTES_DEFAULT,
   parameter int unsigned QUEUE_DEPTH      = udph_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_session_tag,
   output logic [15:0]      rsp_packet_seq,
   output logic [7:0]       rsp_frag_index,
   output logic [7:0]       rsp_frag_total,
   output logic [4:0]       rsp_addr_offset,
   output logic [15:0]      rsp_addr_length,
   output logic [15:0]      rsp_data_length,
   output logic [31:0]      rsp_good_count,
   output logic [31:0]      rsp_short_err_count,
   output logic [31:0]      rsp_bounds_err_count,
   output logic [31:0]      rsp_format_err_count
);

   logic              q_full;
   logic              q_push;
   logic              q_not_empty;
   logic              q_pop;
   udph_pkg::rec_type q_push_rec;
   udph_pkg::rec_type q_head_rec;

   // Byte front end.
   udph_front #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_rec         (q_push_rec)
   );

   // Record queue.
   udph_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (q_push_rec),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .head_rec  (q_head_rec)
   );

   // Classifier, counters and result register.
   udph_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .q_not_empty          (q_not_empty),
      .q_head               (q_head_rec),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_session_tag      (rsp_session_tag),
      .rsp_packet_seq       (rsp_packet_seq),
      .rsp_frag_index       (rsp_frag_index),
      .rsp_frag_total       (rsp_frag_total),
      .rsp_addr_offset      (rsp_addr_offset),
      .rsp_addr_length      (rsp_addr_length),
      .rsp_data_length      (rsp_data_length),
      .rsp_good_count       (rsp_good_count),
      .rsp_short_err_count  (rsp_short_err_count),
      .rsp_bounds_err_count (rsp_bounds_err_count),
      .rsp_format_err_count (rsp_format_err_count)
   );

endmodule

`default_nettype wire
